>>> hdl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB package
// Fixed constants for hue reduction, sector split and the rounding divide.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  // Hue in 1/64 degree units
  localparam logic [15:0] HUE_FULL   = 16'd23040;  // 360 degrees
  localparam logic [15:0] HUE_DOUBLE = 16'd46080;  // 720 degrees
  localparam logic [11:0] HUE_SECTOR = 12'd3840;   // 60 degrees

  // Channel numerator widths
  localparam int unsigned NumW  = 28;
  localparam int unsigned QuotW = 20;

  // Rounding divide by 255*3840 = 256*3825: add half, drop 8 bits, divide by 3825
  localparam logic [NumW-1:0]  ROUND_OFF = 28'd489600;
  localparam logic [11:0]      DIV_REST  = 12'd3825;
  localparam logic [20:0]      RECIP_M   = 21'd1122867;  // floor(2^32 / 3825)
  localparam int unsigned      RecipSh   = 32;
  localparam int unsigned      ProdW     = QuotW + 21;

  // Hue sectors of 60 degrees
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_e;

  // Lanes: floor channel, rising ramp, falling ramp
  localparam int unsigned Lanes     = 3;
  localparam int unsigned LaneFloor = 0;
  localparam int unsigned LaneRise  = 1;
  localparam int unsigned LaneFall  = 2;

  typedef logic [NumW-1:0]  num_t;
  typedef logic [QuotW-1:0] quot_t;

endpackage

`default_nettype wire

>>> hdl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Five-stage pipeline turning hue, saturation and value into 8-bit R, G, B.
// ----------------------------------------------------------------------------
// Registers: one per stage between input accept and output valid.
// Throughput: one item per cycle while out_ready_i is high; each stage reloads
//   in the same cycle that its successor advances, so items follow with no gap.
// Stalls: each stage advances when its successor is empty or advancing.
// Reset: asynchronous active-low; clears all stage valid bits, payload is not reset.
`default_nettype none

module hsv_to_rgb_converter_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [15:0] hue_i,
  input  wire logic [7:0] saturation_i,
  input  wire logic [7:0] brightness_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);

  localparam int unsigned L = hsv2rgb_pkg::Lanes;

  // --------------------------------------------------------------------------
  // Stage valid bits and enables. A stage loads when it is empty or when the
  // stage after it moves on, so bubbles collapse and nothing is dropped.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = ~v5_q | out_ready_i;
  assign en4 = ~v4_q | en5;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: reduce hue modulo 360 degrees, split into sector and position,
  // form v*s (chroma) and v*(255-s) (floor term).
  // --------------------------------------------------------------------------
  logic [15:0] hue_red;
  logic [2:0]  sector_d;
  logic [11:0] pos_d;
  logic [15:0] vs_d, base_d;

  always_comb begin
    // Any 16-bit hue is below three turns: subtract at most two.
    if (hue_i >= hsv2rgb_pkg::HUE_DOUBLE) begin
      hue_red = hue_i - hsv2rgb_pkg::HUE_DOUBLE;
    end else if (hue_i >= hsv2rgb_pkg::HUE_FULL) begin
      hue_red = hue_i - hsv2rgb_pkg::HUE_FULL;
    end else begin
      hue_red = hue_i;
    end

    // Boundaries belong to the sector that starts there.
    if (hue_red >= 16'd19200) begin
      sector_d = hsv2rgb_pkg::SEC_MAGENTA_RED;
      pos_d    = 12'(hue_red - 16'd19200);
    end else if (hue_red >= 16'd15360) begin
      sector_d = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
      pos_d    = 12'(hue_red - 16'd15360);
    end else if (hue_red >= 16'd11520) begin
      sector_d = hsv2rgb_pkg::SEC_CYAN_BLUE;
      pos_d    = 12'(hue_red - 16'd11520);
    end else if (hue_red >= 16'd7680) begin
      sector_d = hsv2rgb_pkg::SEC_GREEN_CYAN;
      pos_d    = 12'(hue_red - 16'd7680);
    end else if (hue_red >= 16'({4'd0, hsv2rgb_pkg::HUE_SECTOR})) begin
      sector_d = hsv2rgb_pkg::SEC_YELLOW_GREEN;
      pos_d    = 12'(hue_red - 16'({4'd0, hsv2rgb_pkg::HUE_SECTOR}));
    end else begin
      sector_d = hsv2rgb_pkg::SEC_RED_YELLOW;
      pos_d    = hue_red[11:0];
    end

    vs_d   = 16'(saturation_i) * 16'(brightness_i);
    base_d = 16'(8'hFF - saturation_i) * 16'(brightness_i);  // v * (255 - s)
  end

  logic [2:0]  sector_s1_q;
  logic [11:0] pos_s1_q;
  logic [15:0] vs_s1_q, base_s1_q;
  logic [7:0]  val_s1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sector_s1_q <= sector_d;
      pos_s1_q    <= pos_d;
      vs_s1_q     <= vs_d;
      base_s1_q   <= base_d;
      val_s1_q    <= brightness_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ramp products v*s*k per lane, and the floor term times 3840.
  // Lane factors: zero for the floor channel, pos rising, 3840-pos falling.
  // --------------------------------------------------------------------------
  logic [11:0]             kfac [L];
  hsv2rgb_pkg::num_t       prod_d [L];
  hsv2rgb_pkg::num_t       base_sh_d;

  always_comb begin
    kfac[hsv2rgb_pkg::LaneFloor] = 12'd0;
    kfac[hsv2rgb_pkg::LaneRise]  = pos_s1_q;
    kfac[hsv2rgb_pkg::LaneFall]  = hsv2rgb_pkg::HUE_SECTOR - pos_s1_q;
    for (int i = 0; i < L; i++) begin
      prod_d[i] = hsv2rgb_pkg::NumW'(vs_s1_q) * hsv2rgb_pkg::NumW'(kfac[i]);
    end
    // base * 3840 = base * 4096 - base * 256
    base_sh_d = hsv2rgb_pkg::NumW'({base_s1_q, 12'd0})
              - hsv2rgb_pkg::NumW'({base_s1_q, 8'd0});
  end

  logic [2:0]         sector_s2_q;
  logic [7:0]         val_s2_q;
  hsv2rgb_pkg::num_t  prod_s2_q [L];
  hsv2rgb_pkg::num_t  base_sh_s2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sector_s2_q  <= sector_s1_q;
      val_s2_q     <= val_s1_q;
      prod_s2_q    <= prod_d;
      base_sh_s2_q <= base_sh_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: numerator plus half the divisor, then drop the 2^8 factor.
  // --------------------------------------------------------------------------
  hsv2rgb_pkg::num_t  sum_d [L];
  hsv2rgb_pkg::quot_t t_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      sum_d[i] = base_sh_s2_q + prod_s2_q[i] + hsv2rgb_pkg::ROUND_OFF;
      t_d[i]   = sum_d[i][hsv2rgb_pkg::NumW-1:8];
    end
  end

  logic [2:0]          sector_s3_q;
  logic [7:0]          val_s3_q;
  hsv2rgb_pkg::quot_t  t_s3_q [L];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sector_s3_q <= sector_s2_q;
      val_s3_q    <= val_s2_q;
      t_s3_q      <= t_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: estimate t / 3825 by reciprocal multiply; may read one low.
  // --------------------------------------------------------------------------
  logic [hsv2rgb_pkg::ProdW-1:0] rprod [L];
  logic [8:0]                    q0_d [L];

  always_comb begin
    for (int i = 0; i < L; i++) begin
      rprod[i] = hsv2rgb_pkg::ProdW'(t_s3_q[i]) * hsv2rgb_pkg::ProdW'(hsv2rgb_pkg::RECIP_M);
      q0_d[i]  = rprod[i][hsv2rgb_pkg::ProdW-1:hsv2rgb_pkg::RecipSh];
    end
  end

  logic [2:0]          sector_s4_q;
  logic [7:0]          val_s4_q;
  hsv2rgb_pkg::quot_t  t_s4_q [L];
  logic [8:0]          q0_s4_q [L];

  always_ff @(posedge clk_i) begin
    if (en4) begin
      sector_s4_q <= sector_s3_q;
      val_s4_q    <= val_s3_q;
      t_s4_q      <= t_s3_q;
      q0_s4_q     <= q0_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: correct the estimate with one compare, then route the channels
  // by sector. The full channel is exactly the value itself.
  // --------------------------------------------------------------------------
  logic [20:0] rem  [L];
  logic [7:0]  chan [L];
  logic [7:0]  red_d, green_d, blue_d;

  always_comb begin
    for (int i = 0; i < L; i++) begin
      rem[i]  = 21'(t_s4_q[i]) - 21'(q0_s4_q[i]) * 21'(hsv2rgb_pkg::DIV_REST);
      chan[i] = (rem[i] >= 21'(hsv2rgb_pkg::DIV_REST)) ? 8'(q0_s4_q[i] + 9'd1)
                                                       : q0_s4_q[i][7:0];
    end

    case (hsv2rgb_pkg::sector_e'(sector_s4_q))
      hsv2rgb_pkg::SEC_RED_YELLOW: begin
        red_d   = val_s4_q;
        green_d = chan[hsv2rgb_pkg::LaneRise];
        blue_d  = chan[hsv2rgb_pkg::LaneFloor];
      end
      hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
        red_d   = chan[hsv2rgb_pkg::LaneFall];
        green_d = val_s4_q;
        blue_d  = chan[hsv2rgb_pkg::LaneFloor];
      end
      hsv2rgb_pkg::SEC_GREEN_CYAN: begin
        red_d   = chan[hsv2rgb_pkg::LaneFloor];
        green_d = val_s4_q;
        blue_d  = chan[hsv2rgb_pkg::LaneRise];
      end
      hsv2rgb_pkg::SEC_CYAN_BLUE: begin
        red_d   = chan[hsv2rgb_pkg::LaneFloor];
        green_d = chan[hsv2rgb_pkg::LaneFall];
        blue_d  = val_s4_q;
      end
      hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
        red_d   = chan[hsv2rgb_pkg::LaneRise];
        green_d = chan[hsv2rgb_pkg::LaneFloor];
        blue_d  = val_s4_q;
      end
      default: begin
        red_d   = val_s4_q;
        green_d = chan[hsv2rgb_pkg::LaneFloor];
        blue_d  = chan[hsv2rgb_pkg::LaneFall];
      end
    endcase
  end

  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire
